@@ src/dpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpmc_pkg: shared types and constants for defect pixel median correction
// Widths, register codes and the word structs passed between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package dpmc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int PIX_W      = 16;
  localparam int ENTRY_W    = PIX_W + 1;
  localparam int RAM_W      = 2 * ENTRY_W;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int PROD_W     = PIX_W + GAIN_W;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NBR_N      = 8;
  localparam int RANK_W     = $clog2(NBR_N + 1);
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;
  localparam int MIN_GOOD   = 5;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(4096);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
    REG_IMAGE_HEIGHT = CFG_IDX_W'(1),
    REG_COMP_ENABLE  = CFG_IDX_W'(2),
    REG_COMP_GAIN    = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic             flag;
    logic [PIX_W-1:0] value;
  } pix_entry_t;

  // clamped settings in use
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic                comp_enable;
    logic [GAIN_W-1:0]   gain;
  } cfg_t;

  // one accepted word, scaled, with the position flags of the centre it releases
  typedef struct packed {
    pix_entry_t        entry;
    logic [ADDR_W-1:0] addr;
    logic              emit;
    logic              last;
    logic              top_ok;
    logic              bot_ok;
    logic              left_ok;
    logic              right_ok;
  } s1_t;

  typedef struct packed {
    pix_entry_t                   centre;
    logic [NBR_N-1:0][PIX_W-1:0]  vals;
    logic [NBR_N-1:0]             mask;
    logic                         last;
  } nbr_t;

endpackage

`default_nettype wire

@@ src/dpmc_in_if.sv @@
// ----------------------------------------------------------------------------
// dpmc_in_if: pixel input channel
// Valid/ready channel carrying one raster pixel word with its defect flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [dpmc_pkg::PIX_W-1:0] pixel_value;
  logic                       is_defective;
  logic                       padding;

  modport source (output valid, output pixel_value, output is_defective, output padding,
                  input ready);
  modport sink   (input valid, input pixel_value, input is_defective, input padding,
                  output ready);
endinterface

`default_nettype wire

@@ src/dpmc_out_if.sv @@
// ----------------------------------------------------------------------------
// dpmc_out_if: corrected pixel output channel
// Valid/ready channel carrying one corrected pixel word and end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpmc_out_if;
  logic                       valid;
  logic                       ready;
  logic [dpmc_pkg::PIX_W-1:0] corrected_pixel;
  logic                       frame_last;

  modport source (output valid, output corrected_pixel, output frame_last, input ready);
  modport sink   (input valid, input corrected_pixel, input frame_last, output ready);
endinterface

`default_nettype wire

@@ src/defect_pixel_median_correction_core.sv @@
// ----------------------------------------------------------------------------
// defect_pixel_median_correction_core: defective pixel correction, 3x3 median
// Gain compensation, two-row line store, neighbour median for flagged pixels.
// ----------------------------------------------------------------------------
// a result passes the input, window and output registers in turn once the word that
//   completes its window (W+1 words after its own pixel) is accepted
// throughput: one word per cycle while no back-pressure stalls it, set by the single-port-read line store
// reset: counters, window and valids clear at once; the line store is not
//   cleared, the first two rows only feed out-of-image neighbours
`default_nettype none

module defect_pixel_median_correction_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dpmc_pkg::CFG_W-1:0]        cfg_data,
  dpmc_in_if.sink                                pix_in,
  dpmc_out_if.source                             pix_out
);

  logic [dpmc_pkg::WIDTH_W-1:0]  image_width;
  logic [dpmc_pkg::HEIGHT_W-1:0] image_height;
  logic                          comp_enable;
  logic [dpmc_pkg::GAIN_W-1:0]   comp_gain;
  dpmc_pkg::cfg_t                cfg;

  dpmc_pkg::s1_t                 s1;
  logic                          s1_valid, s1_ready;
  logic                          rd_en;
  logic [dpmc_pkg::ADDR_W-1:0]   rd_addr;
  dpmc_pkg::nbr_t                s2;
  logic                          s2_valid, s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dpmc_pkg::WIDTH_RESET;
      image_height <= dpmc_pkg::HEIGHT_RESET;
      comp_enable  <= 1'b0;
      comp_gain    <= dpmc_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpmc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[dpmc_pkg::WIDTH_W-1:0];
        dpmc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[dpmc_pkg::HEIGHT_W-1:0];
        dpmc_pkg::REG_COMP_ENABLE:  comp_enable  <= cfg_data[0];
        dpmc_pkg::REG_COMP_GAIN:    comp_gain    <= cfg_data[dpmc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < dpmc_pkg::WIDTH_W'(dpmc_pkg::MIN_WIDTH)) begin
      cfg.width = dpmc_pkg::WIDTH_W'(dpmc_pkg::MIN_WIDTH);
    end else if (image_width > dpmc_pkg::WIDTH_W'(dpmc_pkg::MAX_WIDTH)) begin
      cfg.width = dpmc_pkg::WIDTH_W'(dpmc_pkg::MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    if (image_height < dpmc_pkg::HEIGHT_W'(dpmc_pkg::MIN_HEIGHT)) begin
      cfg.height = dpmc_pkg::HEIGHT_W'(dpmc_pkg::MIN_HEIGHT);
    end else begin
      cfg.height = image_height;
    end
    cfg.comp_enable = comp_enable;
    cfg.gain        = comp_gain;
  end

  // padding words carry no meaning of their own; raster position decides
  dpmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (pix_in.valid),
    .in_pixel     (pix_in.pixel_value),
    .in_defective (pix_in.is_defective),
    .in_ready     (pix_in.ready),
    .s1           (s1),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  dpmc_window u_window (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready)
  );

  dpmc_select u_select (
    .clk       (clk),
    .rst       (rst),
    .s2        (s2),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_pixel (pix_out.corrected_pixel),
    .out_last  (pix_out.frame_last)
  );

  // words that release no centre never reach the select stage
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ready && !s1.emit) |=> !s2_valid)
    else $error("non-emitting word entered neighbour stage");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ready && s1.emit) |=> s2_valid)
    else $error("emitting word lost before neighbour stage");

  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_ready) |=> pix_out.valid)
    else $error("neighbour set did not reach the output register");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_ready) |-> !pix_in.ready)
    else $error("input taken while input register is stalled");

endmodule

`default_nettype wire

@@ src/dpmc_ram.sv @@
// ----------------------------------------------------------------------------
// dpmc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpmc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/dpmc_front.sv @@
// ----------------------------------------------------------------------------
// dpmc_front: input stage
// Raster counters, gain scaling and the input register; issues line store reads.
// ----------------------------------------------------------------------------
`default_nettype none

module dpmc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dpmc_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  input  wire logic [dpmc_pkg::PIX_W-1:0]    in_pixel,
  input  wire logic                          in_defective,
  output      logic                          in_ready,
  output      dpmc_pkg::s1_t                 s1,
  output      logic                          s1_valid,
  input  wire logic                          s1_ready,
  output      logic                          rd_en,
  output      logic [dpmc_pkg::ADDR_W-1:0]   rd_addr
);

  logic [dpmc_pkg::ADDR_W-1:0]  col, col_next;
  logic [dpmc_pkg::ROW_W-1:0]   row, row_next;
  logic [dpmc_pkg::ROW_W-1:0]   h_ext, h_p1, row_p1;
  logic [dpmc_pkg::WIDTH_W-1:0] col_p1;
  logic                         col_nz;
  logic                         in_fire;
  logic [dpmc_pkg::PROD_W-1:0]  prod;
  logic [dpmc_pkg::PIX_W-1:0]   scaled;
  dpmc_pkg::s1_t                s1_next;

  assign in_ready = !s1_valid || s1_ready;
  assign in_fire  = in_valid && in_ready;
  assign rd_en    = in_fire;
  assign rd_addr  = col;

  assign h_ext  = dpmc_pkg::ROW_W'(cfg.height);
  assign h_p1   = h_ext + dpmc_pkg::ROW_W'(1);
  assign row_p1 = row + dpmc_pkg::ROW_W'(1);
  assign col_p1 = dpmc_pkg::WIDTH_W'(col) + dpmc_pkg::WIDTH_W'(1);
  assign col_nz = (col != '0);

  // Q4.12 gain, truncated and saturated
  always_comb begin
    prod = dpmc_pkg::PROD_W'(in_pixel) * dpmc_pkg::PROD_W'(cfg.gain);
    if (!cfg.comp_enable) begin
      scaled = in_pixel;
    end else if (|prod[dpmc_pkg::PROD_W-1:dpmc_pkg::GAIN_FRAC+dpmc_pkg::PIX_W]) begin
      scaled = '1;
    end else begin
      scaled = prod[dpmc_pkg::GAIN_FRAC+dpmc_pkg::PIX_W-1:dpmc_pkg::GAIN_FRAC];
    end
  end

  // the released centre sits one row and one column back; on column zero it is
  // the last column two rows back
  always_comb begin
    s1_next.entry.flag  = in_defective;
    s1_next.entry.value = scaled;
    s1_next.addr        = col;
    s1_next.emit        = (row >= dpmc_pkg::ROW_W'(2) || (row == dpmc_pkg::ROW_W'(1) && col_nz))
                          && (row < h_p1 || (row == h_p1 && !col_nz));
    s1_next.last        = (row == h_p1) && !col_nz;
    s1_next.top_ok      = col_nz ? (row >= dpmc_pkg::ROW_W'(2)) : (row >= dpmc_pkg::ROW_W'(3));
    s1_next.bot_ok      = col_nz ? (row_p1 <= h_ext) : (row <= h_ext);
    s1_next.left_ok     = col_nz ? (col >= dpmc_pkg::ADDR_W'(2)) : 1'b1;
    s1_next.right_ok    = col_nz && (col_p1 <= cfg.width);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (in_fire) begin
      if (row >= h_p1) begin
        col_next = '0;
        row_next = '0;
      end else if (col_p1 >= cfg.width) begin
        col_next = '0;
        row_next = row_p1;
      end else begin
        col_next = col_p1[dpmc_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

@@ src/dpmc_window.sv @@
// ----------------------------------------------------------------------------
// dpmc_window: line store and 3x3 window
// Keeps the two previous rows and builds the neighbour set of each centre.
// ----------------------------------------------------------------------------
`default_nettype none

module dpmc_window (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dpmc_pkg::s1_t                 s1,
  input  wire logic                          s1_valid,
  output      logic                          s1_ready,
  input  wire logic                          rd_en,
  input  wire logic [dpmc_pkg::ADDR_W-1:0]   rd_addr,
  output      dpmc_pkg::nbr_t                s2,
  output      logic                          s2_valid,
  input  wire logic                          s2_ready
);

  logic [dpmc_pkg::RAM_W-1:0] rd_data;
  dpmc_pkg::pix_entry_t       rd_a, rd_b;
  dpmc_pkg::pix_entry_t       win [3][2];
  dpmc_pkg::pix_entry_t       nb [dpmc_pkg::NBR_N];
  logic [dpmc_pkg::NBR_N-1:0] in_img;
  logic                       s1_fire;
  dpmc_pkg::nbr_t             s2_next;

  assign s1_ready = !s2_valid || s2_ready;
  assign s1_fire  = s1_valid && s1_ready;

  // line word holds {two rows back, one row back}
  assign rd_a = rd_data[dpmc_pkg::ENTRY_W-1:0];
  assign rd_b = rd_data[dpmc_pkg::RAM_W-1:dpmc_pkg::ENTRY_W];

  dpmc_ram #(
    .DATA_W (dpmc_pkg::RAM_W),
    .DEPTH  (dpmc_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1.addr),
    .wdata ({rd_a, s1.entry}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // centre is window column 1; the incoming column is its right side
  always_comb begin
    nb[0] = win[0][0];
    nb[1] = win[0][1];
    nb[2] = rd_b;
    nb[3] = win[1][0];
    nb[4] = rd_a;
    nb[5] = win[2][0];
    nb[6] = win[2][1];
    nb[7] = s1.entry;
    in_img[0] = s1.top_ok && s1.left_ok;
    in_img[1] = s1.top_ok;
    in_img[2] = s1.top_ok && s1.right_ok;
    in_img[3] = s1.left_ok;
    in_img[4] = s1.right_ok;
    in_img[5] = s1.bot_ok && s1.left_ok;
    in_img[6] = s1.bot_ok;
    in_img[7] = s1.bot_ok && s1.right_ok;
    s2_next.centre = win[1][1];
    s2_next.last   = s1.last;
    for (int i = 0; i < dpmc_pkg::NBR_N; i++) begin
      s2_next.vals[i] = nb[i].value;
      s2_next.mask[i] = in_img[i] && !nb[i].flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= '0;
        win[r][1] <= '0;
      end
    end else begin
      if (s1_fire) begin
        s2_valid  <= s1.emit;
        win[0][0] <= win[0][1];
        win[1][0] <= win[1][1];
        win[2][0] <= win[2][1];
        win[0][1] <= rd_b;
        win[1][1] <= rd_a;
        win[2][1] <= s1.entry;
      end else if (s2_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2 <= s2_next;
    end
  end

endmodule

`default_nettype wire

@@ src/dpmc_select.sv @@
// ----------------------------------------------------------------------------
// dpmc_select: neighbour median select and output register
// Ranks the usable neighbours in parallel and picks the middle one.
// ----------------------------------------------------------------------------
`default_nettype none

module dpmc_select (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dpmc_pkg::nbr_t              s2,
  input  wire logic                        s2_valid,
  output      logic                        s2_ready,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [dpmc_pkg::PIX_W-1:0]  out_pixel,
  output      logic                        out_last
);

  logic [dpmc_pkg::RANK_W-1:0] rank [dpmc_pkg::NBR_N];
  logic [dpmc_pkg::RANK_W-1:0] cnt, half;
  logic [dpmc_pkg::PIX_W-1:0]  pick, res;
  logic                        less;
  logic                        s2_fire;

  assign s2_ready = !out_valid || out_ready;
  assign s2_fire  = s2_valid && s2_ready;

  // rank with ties broken by position gives a unique sorted order
  always_comb begin
    cnt  = '0;
    pick = '0;
    less = 1'b0;
    for (int i = 0; i < dpmc_pkg::NBR_N; i++) begin
      cnt = cnt + dpmc_pkg::RANK_W'(s2.mask[i]);
    end
    half = cnt >> 1;
    for (int i = 0; i < dpmc_pkg::NBR_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < dpmc_pkg::NBR_N; j++) begin
        less = s2.mask[j] && ((s2.vals[j] < s2.vals[i]) ||
                              ((s2.vals[j] == s2.vals[i]) && (j < i)));
        rank[i] = rank[i] + dpmc_pkg::RANK_W'(less);
      end
      if (s2.mask[i] && (rank[i] == half)) begin
        pick = pick | s2.vals[i];
      end
    end
    if (s2.centre.flag && (cnt >= dpmc_pkg::RANK_W'(dpmc_pkg::MIN_GOOD))) begin
      res = pick;
    end else begin
      res = s2.centre.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_pixel <= res;
      out_last  <= s2.last;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for defect_pixel_median_correction_core
// A short directed run covers the median and keep-own-value cases, then random
// frames run under random gaps, a long output hold and changing register
// settings. Each corrected word is checked against an in-bench model of the
// gain, the two-row window and the neighbour median.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int IDLE_PCT     = 18;
  localparam int QUIET_LO     = 1500;
  localparam int QUIET_HI     = 4500;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 1550;
  localparam int QUEUE_DEPTH  = 256;

  typedef struct packed {
    logic [dpmc_pkg::PIX_W-1:0] value;
    logic                       defect;
    logic                       pad;
  } pix_word_t;

  typedef struct packed {
    logic [dpmc_pkg::PIX_W-1:0] pixel;
    logic                       last;
  } fix_word_t;

  typedef enum int {FILL_FULL, FILL_CLUSTER, FILL_EXTREME} fill_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [dpmc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dpmc_pkg::CFG_W-1:0]     cfg_data;

  dpmc_in_if  pix_in();
  dpmc_out_if pix_out();

  defect_pixel_median_correction_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  always #6 clk = ~clk;

  // model state: scaled value with defect flag on top
  logic [dpmc_pkg::ENTRY_W-1:0]  row1_store [dpmc_pkg::MAX_WIDTH];
  logic [dpmc_pkg::ENTRY_W-1:0]  row2_store [dpmc_pkg::MAX_WIDTH];
  logic [dpmc_pkg::ENTRY_W-1:0]  win [3][3];
  int                            col_pos;
  int                            row_pos;
  logic [dpmc_pkg::WIDTH_W-1:0]  set_width;
  logic [dpmc_pkg::HEIGHT_W-1:0] set_height;
  logic                          set_en;
  logic [dpmc_pkg::GAIN_W-1:0]   set_gain;

  fix_word_t expected_px [$];
  pix_word_t pend_words [$];
  pix_word_t cur_word;
  int        words_posted = 0;
  int        words_taken = 0;
  int        results_seen = 0;
  int        err_cnt = 0;
  int        cyc = 0;
  int        stall_cnt = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  task automatic report(string msg);
    if (err_cnt < 50) $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic bit coin_idle();
    return (cyc < QUIET_LO || cyc >= QUIET_HI) && $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic logic [dpmc_pkg::PIX_W-1:0] apply_gain(logic [dpmc_pkg::PIX_W-1:0] v);
    logic [31:0] prod;
    if (!set_en) return v;
    prod = (32'(v) * 32'(set_gain)) >> dpmc_pkg::GAIN_FRAC;
    return (prod > 32'hFFFF) ? 16'hFFFF : prod[dpmc_pkg::PIX_W-1:0];
  endfunction

  // centre sits in window column k at frame position (rc, cc)
  function automatic logic [dpmc_pkg::PIX_W-1:0] neighbour_median(int k, int rc, int cc,
                                                                  int w, int h);
    logic [dpmc_pkg::ENTRY_W-1:0] centre;
    logic [dpmc_pkg::ENTRY_W-1:0] e;
    logic [dpmc_pkg::PIX_W-1:0]   vals [8];
    logic [dpmc_pkg::PIX_W-1:0]   t;
    int                           n;
    int                           r;
    int                           c;
    int                           col;
    int                           j;
    centre = win[1][k];
    if (!centre[dpmc_pkg::PIX_W]) return centre[dpmc_pkg::PIX_W-1:0];
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = rc + dr;
        c = cc + dc;
        col = k + dc;
        if ((dr != 0 || dc != 0) && r >= 0 && r < h && c >= 0 && c < w &&
            col >= 0 && col <= 2) begin
          e = win[dr + 1][col];
          if (!e[dpmc_pkg::PIX_W]) begin
            vals[n] = e[dpmc_pkg::PIX_W-1:0];
            n++;
          end
        end
      end
    end
    if (n < dpmc_pkg::MIN_GOOD) return centre[dpmc_pkg::PIX_W-1:0];
    for (int i = 1; i < n; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    return vals[n / 2];
  endfunction

  function automatic int eff_width();
    if (set_width < dpmc_pkg::MIN_WIDTH) return dpmc_pkg::MIN_WIDTH;
    if (set_width > dpmc_pkg::MAX_WIDTH) return dpmc_pkg::MAX_WIDTH;
    return int'(set_width);
  endfunction

  function automatic int eff_height();
    return (set_height < dpmc_pkg::MIN_HEIGHT) ? dpmc_pkg::MIN_HEIGHT : int'(set_height);
  endfunction

  task automatic predict_word(pix_word_t wd);
    int                           w;
    int                           h;
    int                           total;
    int                           q;
    int                           p;
    int                           k;
    logic [dpmc_pkg::ENTRY_W-1:0] entry;
    logic [dpmc_pkg::PIX_W-1:0]   res;
    logic                         emit;
    fix_word_t                    fw;
    w = eff_width();
    h = eff_height();
    total = w * h;
    q = row_pos * w + col_pos;
    entry = {wd.defect, apply_gain(wd.value)};
    emit = 1'b0;
    p = 0;
    res = '0;
    if (q >= w + 1) begin
      p = q - (w + 1);
      emit = p < total;
    end
    // at column zero the centre is still in the newest window column
    k = (col_pos == 0) ? 2 : 1;
    if (k == 2 && emit) res = neighbour_median(2, p / w, p % w, w, h);
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = row2_store[col_pos];
    win[1][2] = row1_store[col_pos];
    win[2][2] = entry;
    row2_store[col_pos] = row1_store[col_pos];
    row1_store[col_pos] = entry;
    if (k == 1 && emit) res = neighbour_median(1, p / w, p % w, w, h);
    if (emit) begin
      fw.pixel = res;
      fw.last = (p == total - 1);
      expected_px.insert(expected_px.size(), fw);
    end
    if (q >= total + w) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      pix_in.pixel_value <= '0;
      pix_in.is_defective <= 1'b0;
      pix_in.padding <= 1'b0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        predict_word(cur_word);
        words_taken++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (pend_words.size() != 0 && !coin_idle()) begin
          cur_word = pend_words.pop_front();
          pix_in.valid <= 1'b1;
          pix_in.pixel_value <= cur_word.value;
          pix_in.is_defective <= cur_word.defect;
          pix_in.padding <= cur_word.pad;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and back-pressure
  always @(posedge clk) begin
    fix_word_t want;
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        results_seen++;
        if (expected_px.size() == 0) begin
          report($sformatf("unexpected word %h last %b",
                           pix_out.corrected_pixel, pix_out.frame_last));
        end else begin
          want = expected_px.pop_front();
          if (pix_out.corrected_pixel !== want.pixel)
            report($sformatf("corrected_pixel %h, expected %h",
                             pix_out.corrected_pixel, want.pixel));
          if (pix_out.frame_last !== want.last)
            report($sformatf("frame_last %b, expected %b", pix_out.frame_last, want.last));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pix_out.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 400 && pend_words.size() > 32) begin
        // long hold so the block fills and pushes back on the input
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= !coin_idle();
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic post_word(logic [dpmc_pkg::PIX_W-1:0] v, logic d, logic pd);
    pix_word_t wd;
    while (pend_words.size() >= QUEUE_DEPTH) @(posedge clk);
    wd.value = v;
    wd.defect = d;
    wd.pad = pd;
    pend_words.insert(pend_words.size(), wd);
    words_posted++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (words_taken != words_posted || expected_px.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(dpmc_pkg::cfg_reg_t idx, logic [dpmc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dpmc_pkg::REG_IMAGE_WIDTH:  set_width = val[dpmc_pkg::WIDTH_W-1:0];
      dpmc_pkg::REG_IMAGE_HEIGHT: set_height = val[dpmc_pkg::HEIGHT_W-1:0];
      dpmc_pkg::REG_COMP_ENABLE:  set_en = val[0];
      dpmc_pkg::REG_COMP_GAIN:    set_gain = val[dpmc_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // one frame of w x h pixels, then w+1 flush words
  task automatic send_frame(int w, int h, int defect_pct, fill_t fill, int noise_pct);
    logic [dpmc_pkg::PIX_W-1:0] base;
    logic [dpmc_pkg::PIX_W-1:0] v;
    int                         spread;
    base = dpmc_pkg::PIX_W'($urandom);
    spread = 1 << $urandom_range(2, 12);
    for (int i = 0; i < w * h; i++) begin
      case (fill)
        FILL_FULL:    v = dpmc_pkg::PIX_W'($urandom);
        FILL_CLUSTER: v = base + 16'($urandom_range(spread));
        default:      v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      post_word(v, $urandom_range(99) < defect_pct, $urandom_range(99) < noise_pct);
    end
    // flush words; noisy ones arrive as plain pixels
    for (int i = 0; i <= w; i++)
      post_word(dpmc_pkg::PIX_W'($urandom), 1'($urandom_range(1)),
                $urandom_range(99) >= noise_pct);
  endtask

  task automatic random_phase();
    int                          w_raw;
    int                          h_raw;
    int                          frames;
    int                          dpct;
    int                          sel;
    logic [dpmc_pkg::GAIN_W-1:0] g;
    sel = $urandom_range(99);
    if (sel < 70)      w_raw = $urandom_range(3, 10);
    else if (sel < 85) w_raw = $urandom_range(11, 40);
    else if (sel < 95) w_raw = $urandom_range(0, 2);
    else               w_raw = $urandom_range(64, 260);
    sel = $urandom_range(99);
    if (w_raw >= 64)   h_raw = 2;
    else if (sel < 75) h_raw = $urandom_range(2, 6);
    else if (sel < 90) h_raw = $urandom_range(0, 1);
    else               h_raw = $urandom_range(7, 20);
    sel = $urandom_range(99);
    if (sel < 15)      g = 16'd0;
    else if (sel < 30) g = 16'hFFFF;
    else if (sel < 50) g = dpmc_pkg::GAIN_RESET;
    else if (sel < 75) g = dpmc_pkg::GAIN_W'($urandom_range(2048, 8192));
    else               g = dpmc_pkg::GAIN_W'($urandom);
    write_reg(dpmc_pkg::REG_IMAGE_WIDTH, dpmc_pkg::CFG_W'(w_raw));
    write_reg(dpmc_pkg::REG_IMAGE_HEIGHT, dpmc_pkg::CFG_W'(h_raw));
    write_reg(dpmc_pkg::REG_COMP_ENABLE, dpmc_pkg::CFG_W'($urandom_range(1)));
    write_reg(dpmc_pkg::REG_COMP_GAIN, g);
    frames = (w_raw >= 64) ? 1 : $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      dpct = ($urandom_range(9) == 0) ? 80 : $urandom_range(50);
      send_frame(eff_width(), eff_height(), dpct, fill_t'($urandom_range(2)),
                 ($urandom_range(9) == 0) ? 10 : 0);
    end
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= dpmc_pkg::REG_IMAGE_WIDTH;
    cfg_data <= '0;
    for (int i = 0; i < dpmc_pkg::MAX_WIDTH; i++) begin
      row1_store[i] = '0;
      row2_store[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
    set_width = dpmc_pkg::WIDTH_RESET;
    set_height = dpmc_pkg::HEIGHT_RESET;
    set_en = 1'b0;
    set_gain = dpmc_pkg::GAIN_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // 3x2 frame: top middle defective with five good neighbours
    write_reg(dpmc_pkg::REG_IMAGE_WIDTH, dpmc_pkg::CFG_W'(3));
    write_reg(dpmc_pkg::REG_IMAGE_HEIGHT, dpmc_pkg::CFG_W'(2));
    write_reg(dpmc_pkg::REG_COMP_ENABLE, dpmc_pkg::CFG_W'(0));
    write_reg(dpmc_pkg::REG_COMP_GAIN, dpmc_pkg::GAIN_RESET);
    post_word(16'd100, 1'b0, 1'b0);
    post_word(16'hFFFF, 1'b1, 1'b0);
    post_word(16'd300, 1'b0, 1'b1);   // padding flag inside the frame
    post_word(16'd0, 1'b0, 1'b0);
    post_word(16'd500, 1'b0, 1'b0);
    post_word(16'hFFFF, 1'b0, 1'b0);
    post_word(16'hFFFF, 1'b1, 1'b1);
    post_word(16'd0, 1'b0, 1'b1);
    post_word(16'h1234, 1'b1, 1'b0);  // plain pixel in the flush
    post_word(16'hAAAA, 1'b0, 1'b1);
    wait_idle();

    // 3x3 frame at max gain: corners keep own value, centre gets the median
    write_reg(dpmc_pkg::REG_IMAGE_HEIGHT, dpmc_pkg::CFG_W'(3));
    write_reg(dpmc_pkg::REG_COMP_ENABLE, dpmc_pkg::CFG_W'(1));
    write_reg(dpmc_pkg::REG_COMP_GAIN, 16'hFFFF);
    post_word(16'd10, 1'b1, 1'b0);
    post_word(16'd20, 1'b0, 1'b0);
    post_word(16'd5000, 1'b0, 1'b0);
    post_word(16'd30, 1'b0, 1'b0);
    post_word(16'd40, 1'b1, 1'b0);
    post_word(16'd50, 1'b0, 1'b0);
    post_word(16'd60, 1'b0, 1'b0);
    post_word(16'd0, 1'b0, 1'b0);
    post_word(16'hFFFF, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) post_word(16'h5555, 1'b0, 1'b1);
    wait_idle();

    while (words_posted < RANDOM_WORDS) random_phase();

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
